FILE: hw/rtl/rsic_pkg.sv
// Package for the ray-sphere interval clip block: widths, stage records and queue status.
// No dependencies; the queue, front, back and top-level files use it.
`default_nettype none
package rsic_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int A_W     = 64;
  localparam int BM_W    = 66;
  localparam int CM_W    = 66;
  localparam int DISC_W  = 134;
  localparam int S_W     = DISC_W / 2;
  localparam int REM_W   = S_W + 4;
  localparam int TQ_W    = S_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [A_W-1:0]    a;
    logic [BM_W-1:0]   b_mag;
    logic              b_neg;
    logic [CM_W-1:0]   c_mag;
    logic              c_neg;
    logic [DISC_W-1:0] disc;
    logic              ok;
    logic [31:0]       span_start;
    logic [31:0]       span_end;
  } front_item_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [S_W-1:0]    root;
    front_item_t       item;
  } sq_stage_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } fifo_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rsic_if.sv
// Handshake interfaces for the ray request channel and the clipped result channel.
// No dependencies.
`default_nettype none
interface rsic_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        sphere_radius;
  logic signed [31:0] span_start;
  logic signed [31:0] span_end;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, sphere_radius, span_start, span_end,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                center_x, center_y, center_z, sphere_radius, span_start, span_end,
                output ready);
endinterface

interface rsic_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] new_start;
  logic signed [31:0] new_end;
  modport source (output valid, hit, new_start, new_end, input ready);
  modport sink (input valid, hit, new_start, new_end, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rsic_fifo.sv
// Short queue between the front pipeline and the back pipeline.
// Depends on rsic_pkg.
`default_nettype none
module rsic_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire rsic_pkg::front_item_t item_i,
  input  wire logic                 pop_i,
  output rsic_pkg::front_item_t     item_o,
  output rsic_pkg::fifo_stat_t      stat_o
);
  rsic_pkg::front_item_t mem_q [rsic_pkg::FIFO_DEPTH];
  logic [rsic_pkg::PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [rsic_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d = push_i ? wp_q + rsic_pkg::PTR_W'(1) : wp_q;
    rp_d = pop_i ? rp_q + rsic_pkg::PTR_W'(1) : rp_q;
    cnt_d = cnt_q + rsic_pkg::CNT_W'(push_i) - rsic_pkg::CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  assign item_o = mem_q[rp_q];
  assign stat_o.full = (cnt_q == rsic_pkg::CNT_W'(rsic_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;
endmodule
`default_nettype wire

FILE: hw/rtl/rsic_front.sv
// Front pipeline: forms the quadratic coefficients and the discriminant and classifies the ray.
// Depends on rsic_pkg and rsic_if; feeds rsic_fifo.
`default_nettype none
module rsic_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            mode_i,
  rsic_ray_if.sink             ray_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output rsic_pkg::front_item_t item_o
);
  logic [7:1] v_q;
  logic en;

  logic signed [31:0] s1_d_q [3];
  logic signed [32:0] s1_oc_q [3];
  logic [31:0]        s1_r_q;
  logic [31:0]        s1_st_q, s1_en_q;

  logic signed [63:0] s2_dd_q [3];
  logic signed [64:0] s2_doc_q [3];
  logic signed [65:0] s2_oo_q [3];
  logic [63:0]        s2_rr_q;
  logic [31:0]        s2_st_q, s2_en_q;

  logic [63:0]        s3_a_q;
  logic signed [66:0] s3_b_q, s3_c_q, s3_b_d, s3_c_d;
  logic [31:0]        s3_st_q, s3_en_q;

  logic [63:0] s4_a_q;
  logic [65:0] s4_bm_q, s4_cm_q;
  logic        s4_bn_q, s4_cn_q;
  logic [31:0] s4_st_q, s4_en_q;

  logic [65:0] s5_bhh_q, s5_bhl_q, s5_bll_q;
  logic [64:0] s5_ahch_q, s5_ahcl_q, s5_alch_q, s5_alcl_q;
  logic [63:0] s5_a_q;
  logic        s5_anz_q;
  logic [65:0] s5_bm_q, s5_cm_q;
  logic        s5_bn_q, s5_cn_q;
  logic [31:0] s5_st_q, s5_en_q;

  logic [133:0] s6_bb_q, s6_ac_q;
  logic [63:0]  s6_a_q;
  logic         s6_anz_q;
  logic [65:0]  s6_bm_q, s6_cm_q;
  logic         s6_bn_q, s6_cn_q;
  logic [31:0]  s6_st_q, s6_en_q;

  rsic_pkg::front_item_t s7_q, s7_d;

  assign en = !v_q[7] || !full_i;
  assign ray_i.ready = en;
  assign push_o = v_q[7] && !full_i;
  assign item_o = s7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:1], ray_i.valid};
    end
  end

  always_comb begin
    s3_b_d = (67'(s2_doc_q[0]) + 67'(s2_doc_q[1]) + 67'(s2_doc_q[2])) <<< 1;
    s3_c_d = 67'(s2_oo_q[0]) + 67'(s2_oo_q[1]) + 67'(s2_oo_q[2]) - $signed(67'(s2_rr_q));
  end

  always_comb begin
    s7_d.a = s6_a_q;
    s7_d.b_mag = s6_bm_q;
    s7_d.b_neg = s6_bn_q;
    s7_d.c_mag = s6_cm_q;
    s7_d.c_neg = s6_cn_q;
    s7_d.span_start = s6_st_q;
    s7_d.span_end = s6_en_q;
    if (s6_cn_q) begin
      s7_d.disc = s6_bb_q + s6_ac_q;
      s7_d.ok = s6_anz_q;
    end else begin
      s7_d.disc = s6_bb_q - s6_ac_q;
      s7_d.ok = s6_anz_q && (s6_ac_q <= s6_bb_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_d_q[0] <= ray_i.dir_x;
      s1_d_q[1] <= ray_i.dir_y;
      s1_d_q[2] <= ray_i.dir_z;
      s1_oc_q[0] <= 33'(ray_i.origin_x) - 33'(ray_i.center_x);
      s1_oc_q[1] <= 33'(ray_i.origin_y) - 33'(ray_i.center_y);
      s1_oc_q[2] <= 33'(ray_i.origin_z) - 33'(ray_i.center_z);
      s1_r_q <= mode_i ? {ray_i.sphere_radius, 1'b0} : {1'b0, ray_i.sphere_radius};
      s1_st_q <= ray_i.span_start;
      s1_en_q <= ray_i.span_end;

      for (int i = 0; i < 3; i++) begin
        s2_dd_q[i] <= 64'(s1_d_q[i]) * 64'(s1_d_q[i]);
        s2_doc_q[i] <= 65'(s1_d_q[i]) * 65'(s1_oc_q[i]);
        s2_oo_q[i] <= 66'(s1_oc_q[i]) * 66'(s1_oc_q[i]);
      end
      s2_rr_q <= 64'(s1_r_q) * 64'(s1_r_q);
      s2_st_q <= s1_st_q;
      s2_en_q <= s1_en_q;

      s3_a_q <= 64'(s2_dd_q[0]) + 64'(s2_dd_q[1]) + 64'(s2_dd_q[2]);
      s3_b_q <= s3_b_d;
      s3_c_q <= s3_c_d;
      s3_st_q <= s2_st_q;
      s3_en_q <= s2_en_q;

      s4_a_q <= s3_a_q;
      s4_bn_q <= s3_b_q[66];
      s4_bm_q <= s3_b_q[66] ? 66'(-s3_b_q) : s3_b_q[65:0];
      s4_cn_q <= s3_c_q[66];
      s4_cm_q <= s3_c_q[66] ? 66'(-s3_c_q) : s3_c_q[65:0];
      s4_st_q <= s3_st_q;
      s4_en_q <= s3_en_q;

      s5_bhh_q <= 66'(s4_bm_q[65:33]) * 66'(s4_bm_q[65:33]);
      s5_bhl_q <= 66'(s4_bm_q[65:33]) * 66'(s4_bm_q[32:0]);
      s5_bll_q <= 66'(s4_bm_q[32:0]) * 66'(s4_bm_q[32:0]);
      s5_ahch_q <= 65'(s4_a_q[63:32]) * 65'(s4_cm_q[65:33]);
      s5_ahcl_q <= 65'(s4_a_q[63:32]) * 65'(s4_cm_q[32:0]);
      s5_alch_q <= 65'(s4_a_q[31:0]) * 65'(s4_cm_q[65:33]);
      s5_alcl_q <= 65'(s4_a_q[31:0]) * 65'(s4_cm_q[32:0]);
      s5_a_q <= s4_a_q;
      s5_anz_q <= (s4_a_q != '0);
      s5_bm_q <= s4_bm_q;
      s5_bn_q <= s4_bn_q;
      s5_cm_q <= s4_cm_q;
      s5_cn_q <= s4_cn_q;
      s5_st_q <= s4_st_q;
      s5_en_q <= s4_en_q;

      s6_bb_q <= (134'(s5_bhh_q) << 66) + (134'(s5_bhl_q) << 34) + 134'(s5_bll_q);
      s6_ac_q <= ((134'(s5_ahch_q) << 65) + (134'(s5_ahcl_q) << 32)
                + (134'(s5_alch_q) << 33) + 134'(s5_alcl_q)) << 2;
      s6_a_q <= s5_a_q;
      s6_anz_q <= s5_anz_q;
      s6_bm_q <= s5_bm_q;
      s6_bn_q <= s5_bn_q;
      s6_cm_q <= s5_cm_q;
      s6_cn_q <= s5_cn_q;
      s6_st_q <= s5_st_q;
      s6_en_q <= s5_en_q;

      s7_q <= s7_d;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rsic_back.sv
// Back pipeline: square root, the two root divisions, saturation and interval clipping.
// Depends on rsic_pkg and rsic_if; drains rsic_fifo.
`default_nettype none
module rsic_back #(
  parameter int FRAC_BITS = rsic_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rsic_pkg::front_item_t item_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  rsic_res_if.source                res_o
);
  localparam int SW = rsic_pkg::S_W;
  localparam int TW = rsic_pkg::TQ_W;
  localparam int DivW = TW + FRAC_BITS;

  typedef struct packed {
    logic [TW-1:0]   rem0;
    logic [TW-1:0]   rem1;
    logic [DivW-1:0] quo0;
    logic [DivW-1:0] quo1;
    logic [DivW-1:0] num0;
    logic [DivW-1:0] num1;
    logic [TW-1:0]   den0;
    logic [TW-1:0]   den1;
    logic            q_neg;
    logic            c_neg;
    logic            tq_zero;
    logic            ok;
    logic [31:0]     span_start;
    logic [31:0]     span_end;
  } dv_stage_t;

  logic en;
  logic sqv_q [SW+1];
  logic dvv_q [DivW+1];
  logic stv_q, res_v_q;
  rsic_pkg::sq_stage_t sq_q [SW+1];
  rsic_pkg::sq_stage_t sq_d [SW+1];
  dv_stage_t dv_q [DivW+1];
  dv_stage_t dv_d [DivW+1];
  logic [TW-1:0] tq;

  logic signed [31:0] st_t0_q, st_t1_q, st_t0_d, st_t1_d;
  logic        st_ok_q;
  logic [31:0] st_s_q, st_e_q;
  logic signed [31:0] lo, hi, ss, se;
  logic        hit_q;
  logic [31:0] ns_q, ne_q;

  function automatic rsic_pkg::sq_stage_t sq_step(input rsic_pkg::sq_stage_t s, input int k);
    rsic_pkg::sq_stage_t r;
    logic [rsic_pkg::REM_W-1:0] rem2, trial;
    logic ge;
    r = s;
    rem2 = {s.rem[rsic_pkg::REM_W-3:0], s.item.disc[rsic_pkg::DISC_W-1-2*k -: 2]};
    trial = rsic_pkg::REM_W'({s.root, 2'b01});
    ge = (rem2 >= trial);
    r.rem = ge ? rem2 - trial : rem2;
    r.root = {s.root[SW-2:0], ge};
    return r;
  endfunction

  function automatic dv_stage_t dv_step(input dv_stage_t s, input int k);
    dv_stage_t r;
    logic [TW:0] p0, p1;
    logic g0, g1;
    r = s;
    p0 = {s.rem0, s.num0[DivW-1-k]};
    p1 = {s.rem1, s.num1[DivW-1-k]};
    g0 = (p0 >= {1'b0, s.den0});
    g1 = (p1 >= {1'b0, s.den1});
    r.rem0 = g0 ? TW'(p0 - {1'b0, s.den0}) : TW'(p0);
    r.rem1 = g1 ? TW'(p1 - {1'b0, s.den1}) : TW'(p1);
    r.quo0 = {s.quo0[DivW-2:0], g0};
    r.quo1 = {s.quo1[DivW-2:0], g1};
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic [DivW-1:0] mag, input logic neg);
    logic big;
    big = (mag[DivW-1:31] != '0);
    if (neg) begin
      return big ? 32'sh8000_0000 : -$signed(mag[31:0]);
    end
    return big ? 32'sh7fff_ffff : $signed(mag[31:0]);
  endfunction

  assign en = !res_v_q || res_o.ready;
  assign pop_o = en && !empty_i;

  always_comb begin
    sq_d[0].rem = '0;
    sq_d[0].root = '0;
    sq_d[0].item = item_i;
    for (int k = 0; k < SW; k++) begin
      sq_d[k+1] = sq_step(sq_q[k], k);
    end
  end

  always_comb begin
    tq = TW'(sq_q[SW].item.b_mag) + TW'(sq_q[SW].root);
    dv_d[0].rem0 = '0;
    dv_d[0].rem1 = '0;
    dv_d[0].quo0 = '0;
    dv_d[0].quo1 = '0;
    dv_d[0].num0 = DivW'(tq) << FRAC_BITS;
    dv_d[0].num1 = DivW'(sq_q[SW].item.c_mag) << (FRAC_BITS + 1);
    dv_d[0].den0 = TW'({sq_q[SW].item.a, 1'b0});
    dv_d[0].den1 = tq;
    dv_d[0].q_neg = !sq_q[SW].item.b_neg && (tq != '0);
    dv_d[0].c_neg = sq_q[SW].item.c_neg;
    dv_d[0].tq_zero = (tq == '0);
    dv_d[0].ok = sq_q[SW].item.ok;
    dv_d[0].span_start = sq_q[SW].item.span_start;
    dv_d[0].span_end = sq_q[SW].item.span_end;
    for (int k = 0; k < DivW; k++) begin
      dv_d[k+1] = dv_step(dv_q[k], k);
    end
  end

  always_comb begin
    st_t0_d = sat32(dv_q[DivW].quo0, dv_q[DivW].q_neg);
    st_t1_d = dv_q[DivW].tq_zero ? $signed(dv_q[DivW].span_start)
            : sat32(dv_q[DivW].quo1, dv_q[DivW].c_neg != dv_q[DivW].q_neg);
    lo = (st_t0_q > st_t1_q) ? st_t1_q : st_t0_q;
    hi = (st_t0_q > st_t1_q) ? st_t0_q : st_t1_q;
    ss = $signed(st_s_q);
    se = $signed(st_e_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= SW; k++) begin
        sqv_q[k] <= 1'b0;
      end
      for (int k = 0; k <= DivW; k++) begin
        dvv_q[k] <= 1'b0;
      end
      stv_q <= 1'b0;
      res_v_q <= 1'b0;
    end else if (en) begin
      sqv_q[0] <= !empty_i;
      for (int k = 0; k < SW; k++) begin
        sqv_q[k+1] <= sqv_q[k];
      end
      dvv_q[0] <= sqv_q[SW];
      for (int k = 0; k < DivW; k++) begin
        dvv_q[k+1] <= dvv_q[k];
      end
      stv_q <= dvv_q[DivW];
      res_v_q <= stv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= SW; k++) begin
        sq_q[k] <= sq_d[k];
      end
      for (int k = 0; k <= DivW; k++) begin
        dv_q[k] <= dv_d[k];
      end
      st_t0_q <= st_t0_d;
      st_t1_q <= st_t1_d;
      st_ok_q <= dv_q[DivW].ok;
      st_s_q <= dv_q[DivW].span_start;
      st_e_q <= dv_q[DivW].span_end;
      if (st_ok_q) begin
        hit_q <= (hi > lo);
        ns_q <= (lo > ss) ? lo : ss;
        ne_q <= (hi < se) ? hi : se;
      end else begin
        hit_q <= 1'b0;
        ns_q <= st_s_q;
        ne_q <= st_e_q;
      end
    end
  end

  assign res_o.valid = res_v_q;
  assign res_o.hit = hit_q;
  assign res_o.new_start = ns_q;
  assign res_o.new_end = ne_q;
endmodule
`default_nettype wire

FILE: hw/rtl/ray_sphere_interval_clip.sv
// Stages in order: the front pipeline, the queue, 67 square-root steps, a setup stage,
// 68 + FRAC_BITS divide steps (one bit per step) and the st_* and result registers.
// Throughput: one request per cycle, held back by a full queue or by res_o.ready low.
// Reset clears the mode register, the queue and all valid flags at once.
// Depends on rsic_pkg, rsic_if, rsic_front, rsic_fifo and rsic_back.
`default_nettype none
module ray_sphere_interval_clip #(
  parameter int FRAC_BITS = rsic_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  rsic_ray_if.sink   ray_i,
  rsic_res_if.source res_o
);
  logic mode_q;
  logic push, pop;
  rsic_pkg::front_item_t f_item, q_item;
  rsic_pkg::fifo_stat_t  q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  rsic_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .ray_i  (ray_i),
    .full_i (q_stat.full),
    .push_o (push),
    .item_o (f_item)
  );

  rsic_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  rsic_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (q_item),
    .empty_i (q_stat.empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("queue read while empty");
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push && !pop) |=> $stable(q_stat.count)) else $error("queue count moved while idle");
endmodule
`default_nettype wire
